// ===== sv/sndt_pkg.sv =====
`timescale 1ns / 1ps

package sndt_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 1024;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 16;
  localparam int unsigned ROW_SW        = 18;
  localparam int unsigned SQRT_STEPS    = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH,
    CFG_FRAME_HEIGHT,
    CFG_LOW_THR,
    CFG_HIGH_THR
  } cfg_idx_t;

  localparam logic [10:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [15:0] FRAME_HEIGHT_RST = 16'd480;
  localparam logic [7:0]  LOW_THR_RST      = 8'd50;
  localparam logic [7:0]  HIGH_THR_RST     = 8'd100;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  localparam logic [1:0] SEC_HORZ    = 2'd0;
  localparam logic [1:0] SEC_DIAG_UP = 2'd1;
  localparam logic [1:0] SEC_VERT    = 2'd2;
  localparam logic [1:0] SEC_DIAG_DN = 2'd3;

  localparam logic [7:0] EDGE_STRONG = 8'd255;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_WIN,
    ST_GRAD,
    ST_MUL1,
    ST_MUL2,
    ST_SQRT,
    ST_NMS,
    ST_EVAL,
    ST_OUT
  } state_t;

endpackage

// ===== sv/sobel_nms_double_threshold_unit.sv =====
// A request is accepted while in_ready is high; its result appears on out_valid after
// line-store reads and writes, gradient, two multiply stages and an 11-step square root.
// No new request is taken before the last is through (with its output stage if it has a
// result); a drain tick with no result leaves the unit idle. A result held back by out_ready
// stalls the next result in the last stage until the output register frees up.
// Reset (rst_n low, synchronous) restores the default geometry and thresholds and
// clears counters and windows; line stores are not cleared.
`timescale 1ns / 1ps

module sobel_nms_double_threshold_unit #(
  parameter int unsigned MAX_WIDTH = sndt_pkg::MAX_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_kind,
  input  logic [7:0]                       in_pixel,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       out_edge_res,
  output logic                             out_end_of_line,
  output logic                             out_end_of_frame,
  input  logic                             cfg_we,
  input  logic [sndt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sndt_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned WID_W = $clog2(MAX_WIDTH + 1);
  localparam int unsigned AW    = $clog2(2 * MAX_WIDTH);
  localparam int unsigned RS    = sndt_pkg::ROW_SW;

  function automatic logic [AW-1:0] line_addr(input logic par, input logic [COL_W-1:0] col);
    logic [AW-1:0] base;
    base = par ? AW'(MAX_WIDTH) : '0;
    return base + AW'(col);
  endfunction

  sndt_pkg::state_t state_r, state_nxt;

  logic [10:0] frame_width_r;
  logic [15:0] frame_height_r;
  logic [7:0]  low_thr_r, high_thr_r;

  logic [7:0] pix_mem [2*MAX_WIDTH];
  logic [7:0] mag_mem [2*MAX_WIDTH];
  logic [1:0] dir_mem [MAX_WIDTH];

  logic [7:0] pwin_r [9];
  logic [7:0] mwin_r [9];
  logic [1:0] dwin_r [3];

  logic [15:0]      in_row_r, out_row_r;
  logic [COL_W-1:0] in_col_r, out_col_r;

  logic signed [RS-1:0] ir_r, mr_r;
  logic [COL_W-1:0]     ic_r, mc_r;
  logic [7:0]           pix_r, pix_top_r, pix_mid_r, mtop_r, mmid_r;
  logic [1:0]           dold_r, d_r;
  logic                 drain_r, emit_r, grad_ok_r;
  logic signed [10:0]   gx_r, gy_r;
  logic [9:0]           ax_r, ay_r;
  logic                 gxneg_r;
  logic [20:0]          sq_r, sr_r;
  logic [3:0]           cnt_r;
  logic [7:0]           res_val_r;
  logic                 res_eol_r, res_eof_r;
  logic                 out_valid_r;
  logic [7:0]           out_edge_r;
  logic                 out_eol_r, out_eof_r;

  // effective geometry
  logic [12:0]      fw_ext;
  logic [WID_W-1:0] w_eff;
  logic [15:0]      h_eff;
  logic signed [RS-1:0] h_s;

  assign fw_ext = {2'b00, frame_width_r};
  always_comb begin
    if (fw_ext < 13'd3) begin
      w_eff = WID_W'(3);
    end else if (fw_ext > 13'(MAX_WIDTH)) begin
      w_eff = WID_W'(MAX_WIDTH);
    end else begin
      w_eff = WID_W'(fw_ext);
    end
  end
  assign h_eff = (frame_height_r < 16'd3) ? 16'd3 : frame_height_r;
  assign h_s   = $signed({2'b00, h_eff});

  // counter normalization at request time
  logic [16:0]      irn, orn, ir_inc;
  logic [15:0]      in_row_n, out_row_n;
  logic [COL_W-1:0] in_col_n, out_col_n;
  logic [WID_W-1:0] ic_inc;
  logic [15:0]      in_row_next;
  logic [COL_W-1:0] in_col_next;
  logic             emit, drain_ok, accept, is_drain, go;
  logic [WID_W:0]   dcol;
  logic signed [RS-1:0] drow;

  always_comb begin
    in_col_n = in_col_r;
    irn      = {1'b0, in_row_r};
    if (WID_W'(in_col_r) >= w_eff) begin
      in_col_n = '0;
      irn      = irn + 17'd1;
    end
    if (irn >= {1'b0, h_eff}) irn = '0;
    in_row_n = irn[15:0];

    out_col_n = out_col_r;
    orn       = {1'b0, out_row_r};
    if (WID_W'(out_col_r) >= w_eff) begin
      out_col_n = '0;
      orn       = orn + 17'd1;
    end
    if (orn >= {1'b0, h_eff}) orn = '0;
    out_row_n = orn[15:0];

    ic_inc      = WID_W'(in_col_n) + WID_W'(1);
    in_col_next = in_col_n + COL_W'(1);
    in_row_next = in_row_n;
    if (ic_inc >= w_eff) begin
      in_col_next = '0;
      ir_inc      = {1'b0, in_row_n} + 17'd1;
      in_row_next = (ir_inc >= {1'b0, h_eff}) ? 16'd0 : ir_inc[15:0];
    end else begin
      ir_inc = {1'b0, in_row_n};
    end

    emit     = (in_row_n >= 16'd3) || (in_row_n == 16'd2 && in_col_n >= COL_W'(2));
    drain_ok = (in_row_n == 16'd0) && (in_col_n == '0) &&
               !((out_row_n == 16'd0) && (out_col_n == '0));

    dcol = {1'b0, WID_W'(out_col_n)} + (WID_W+1)'(2);
    drow = $signed({2'b00, out_row_n}) + RS'(2);
    if (dcol >= {1'b0, w_eff}) begin
      dcol = dcol - {1'b0, w_eff};
      drow = drow + RS'(1);
    end
  end

  assign accept   = in_valid && (state_r == sndt_pkg::ST_IDLE);
  assign is_drain = (in_kind == sndt_pkg::KIND_DRAIN);
  assign go       = !is_drain || drain_ok;

  // read stage helpers
  logic signed [RS-1:0] mr_c;
  logic [COL_W-1:0]     mc_c;
  always_comb begin
    if (ic_r != '0) begin
      mr_c = ir_r - RS'(1);
      mc_c = ic_r - COL_W'(1);
    end else begin
      mr_c = ir_r - RS'(2);
      mc_c = COL_W'(w_eff - WID_W'(1));
    end
  end

  logic [AW-1:0] pa_top, pa_mid, ma_top, ma_mid;
  assign pa_top = line_addr(ir_r[0], ic_r);
  assign pa_mid = line_addr(~ir_r[0], ic_r);
  assign ma_top = line_addr(mr_r[0], mc_r);
  assign ma_mid = line_addr(~mr_r[0], mc_r);

  // gradient
  logic [9:0]         gx_p, gx_n, gy_p, gy_n;
  logic signed [10:0] gx_c, gy_c, gxf, gyf;
  assign gx_p = {2'b00, pwin_r[2]} + {1'b0, pwin_r[5], 1'b0} + {2'b00, pwin_r[8]};
  assign gx_n = {2'b00, pwin_r[0]} + {1'b0, pwin_r[3], 1'b0} + {2'b00, pwin_r[6]};
  assign gy_p = {2'b00, pwin_r[0]} + {1'b0, pwin_r[1], 1'b0} + {2'b00, pwin_r[2]};
  assign gy_n = {2'b00, pwin_r[6]} + {1'b0, pwin_r[7], 1'b0} + {2'b00, pwin_r[8]};
  assign gx_c = $signed({1'b0, gx_p}) - $signed({1'b0, gx_n});
  assign gy_c = $signed({1'b0, gy_p}) - $signed({1'b0, gy_n});
  assign gxf  = gy_r[10] ? -gx_r : gx_r;
  assign gyf  = gy_r[10] ? -gy_r : gy_r;

  logic [9:0]  ax_c, ay_c, gxa, gya;
  logic [20:0] sq_c;
  assign ax_c = gxf[10] ? 10'(-gxf) : gxf[9:0];
  assign ay_c = gyf[9:0];
  assign gxa  = gx_r[10] ? 10'(-gx_r) : gx_r[9:0];
  assign gya  = gy_r[10] ? 10'(-gy_r) : gy_r[9:0];
  assign sq_c = 21'(gxa * gxa) + 21'(gya * gya);

  // sector compare
  logic [10:0] s_c;
  logic [9:0]  t_c;
  logic [21:0] s2, a2, t2;
  logic        below22, below67;
  logic [1:0]  d_c;
  assign s_c = {1'b0, ay_r} + {1'b0, ax_r};
  assign t_c = (ay_r > ax_r) ? (ay_r - ax_r) : 10'd0;
  assign s2  = 22'(s_c) * 22'(s_c);
  assign a2  = {22'(ax_r) * 22'(ax_r)} << 1;
  assign t2  = 22'(t_c) * 22'(t_c);
  assign below22 = s2 < a2;
  assign below67 = (ay_r <= ax_r) || (t2 < a2);
  always_comb begin
    if ((ax_r == 10'd0 && ay_r == 10'd0) || below22) begin
      d_c = sndt_pkg::SEC_HORZ;
    end else if (!below67) begin
      d_c = sndt_pkg::SEC_VERT;
    end else begin
      d_c = gxneg_r ? sndt_pkg::SEC_DIAG_DN : sndt_pkg::SEC_DIAG_UP;
    end
  end

  // square root step
  logic [20:0] bitv;
  logic [21:0] rb;
  assign bitv = 21'(1) << (5'd20 - {cnt_r, 1'b0});
  assign rb   = 22'(sr_r) + 22'(bitv);

  logic [7:0] m_c;
  logic [1:0] dm_c;
  assign m_c  = !grad_ok_r ? 8'd0 : ((sr_r > 21'd255) ? 8'd255 : sr_r[7:0]);
  assign dm_c = grad_ok_r ? d_r : sndt_pkg::SEC_HORZ;

  // evaluation
  logic signed [RS-1:0] cr, nr;
  logic [COL_W-1:0]     cc, nc, adv_col;
  logic [WID_W-1:0]     adv_c;
  logic [16:0]          adv_r;
  logic [15:0]          adv_row;
  logic [7:0]           pv, qv, v, val;
  logic                 in_ring;
  always_comb begin
    if (mc_r != '0) begin
      cr = mr_r - RS'(1);
      cc = mc_r - COL_W'(1);
    end else begin
      cr = mr_r - RS'(2);
      cc = COL_W'(w_eff - WID_W'(1));
    end
    in_ring = (cc >= COL_W'(1)) && (WID_W'(cc) <= w_eff - WID_W'(2)) &&
              (cr >= RS'(1)) && (cr <= h_s - RS'(2));
    case (dwin_r[1])
      sndt_pkg::SEC_HORZ:    begin pv = mwin_r[5]; qv = mwin_r[3]; end
      sndt_pkg::SEC_DIAG_UP: begin pv = mwin_r[6]; qv = mwin_r[2]; end
      sndt_pkg::SEC_VERT:    begin pv = mwin_r[7]; qv = mwin_r[1]; end
      default:               begin pv = mwin_r[0]; qv = mwin_r[8]; end
    endcase
    v = (mwin_r[4] >= pv && mwin_r[4] >= qv) ? mwin_r[4] : 8'd0;
    if (!in_ring || v <= low_thr_r) begin
      val = 8'd0;
    end else if (v < high_thr_r) begin
      val = low_thr_r;
    end else begin
      val = sndt_pkg::EDGE_STRONG;
    end
    if (drain_r) begin
      nr = $signed({2'b00, out_row_r});
      nc = out_col_r;
    end else begin
      nr = cr;
      nc = cc;
    end
    adv_c   = WID_W'(nc) + WID_W'(1);
    adv_col = nc + COL_W'(1);
    adv_row = nr[15:0];
    adv_r   = nr[16:0];
    if (adv_c >= w_eff) begin
      adv_col = '0;
      adv_r   = nr[16:0] + 17'd1;
      adv_row = (adv_r >= {1'b0, h_eff}) ? 16'd0 : adv_r[15:0];
    end
  end

  logic out_free;
  assign out_free = !out_valid_r || out_ready;

  // state machine
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sndt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sndt_pkg::ST_IDLE: if (accept && go) state_nxt = sndt_pkg::ST_READ;
      sndt_pkg::ST_READ: state_nxt = sndt_pkg::ST_WIN;
      sndt_pkg::ST_WIN:  state_nxt = sndt_pkg::ST_GRAD;
      sndt_pkg::ST_GRAD: state_nxt = sndt_pkg::ST_MUL1;
      sndt_pkg::ST_MUL1: state_nxt = sndt_pkg::ST_MUL2;
      sndt_pkg::ST_MUL2: state_nxt = sndt_pkg::ST_SQRT;
      sndt_pkg::ST_SQRT: if (cnt_r == 4'(sndt_pkg::SQRT_STEPS - 1)) state_nxt = sndt_pkg::ST_NMS;
      sndt_pkg::ST_NMS:  state_nxt = sndt_pkg::ST_EVAL;
      sndt_pkg::ST_EVAL: state_nxt = (drain_r || emit_r) ? sndt_pkg::ST_OUT : sndt_pkg::ST_IDLE;
      sndt_pkg::ST_OUT:  if (out_free) state_nxt = sndt_pkg::ST_IDLE;
      default:           state_nxt = sndt_pkg::ST_IDLE;
    endcase
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= sndt_pkg::FRAME_WIDTH_RST;
      frame_height_r <= sndt_pkg::FRAME_HEIGHT_RST;
      low_thr_r      <= sndt_pkg::LOW_THR_RST;
      high_thr_r     <= sndt_pkg::HIGH_THR_RST;
    end else if (cfg_we) begin
      case (sndt_pkg::cfg_idx_t'(cfg_index))
        sndt_pkg::CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data[10:0];
        sndt_pkg::CFG_FRAME_HEIGHT: frame_height_r <= cfg_data[15:0];
        sndt_pkg::CFG_LOW_THR:      low_thr_r      <= cfg_data[7:0];
        sndt_pkg::CFG_HIGH_THR:     high_thr_r     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // counters and windows
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_row_r  <= '0;
      in_col_r  <= '0;
      out_row_r <= '0;
      out_col_r <= '0;
      for (int i = 0; i < 9; i++) begin
        pwin_r[i] <= '0;
        mwin_r[i] <= '0;
      end
      for (int i = 0; i < 3; i++) dwin_r[i] <= '0;
    end else begin
      if (accept) begin
        out_row_r <= out_row_n;
        out_col_r <= out_col_n;
        if (is_drain) begin
          in_row_r <= in_row_n;
          in_col_r <= in_col_n;
        end else begin
          in_row_r <= in_row_next;
          in_col_r <= in_col_next;
        end
      end
      if (state_r == sndt_pkg::ST_WIN) begin
        pwin_r[0] <= pwin_r[1]; pwin_r[1] <= pwin_r[2]; pwin_r[2] <= pix_top_r;
        pwin_r[3] <= pwin_r[4]; pwin_r[4] <= pwin_r[5]; pwin_r[5] <= pix_mid_r;
        pwin_r[6] <= pwin_r[7]; pwin_r[7] <= pwin_r[8]; pwin_r[8] <= pix_r;
      end
      if (state_r == sndt_pkg::ST_NMS) begin
        mwin_r[0] <= mwin_r[1]; mwin_r[1] <= mwin_r[2]; mwin_r[2] <= mtop_r;
        mwin_r[3] <= mwin_r[4]; mwin_r[4] <= mwin_r[5]; mwin_r[5] <= mmid_r;
        mwin_r[6] <= mwin_r[7]; mwin_r[7] <= mwin_r[8]; mwin_r[8] <= m_c;
        dwin_r[0] <= dwin_r[1]; dwin_r[1] <= dwin_r[2]; dwin_r[2] <= dold_r;
      end
      if (state_r == sndt_pkg::ST_EVAL) begin
        if (drain_r || emit_r) begin
          out_row_r <= adv_row;
          out_col_r <= adv_col;
        end else begin
          out_row_r <= '0;
          out_col_r <= '0;
        end
      end
    end
  end

  // line stores
  always_ff @(posedge clk) begin
    if (state_r == sndt_pkg::ST_READ) begin
      pix_top_r <= pix_mem[pa_top];
      pix_mid_r <= pix_mem[pa_mid];
    end
    if (state_r == sndt_pkg::ST_WIN) pix_mem[pa_top] <= pix_r;
  end

  always_ff @(posedge clk) begin
    if (state_r == sndt_pkg::ST_WIN) begin
      mtop_r <= mag_mem[ma_top];
      mmid_r <= mag_mem[ma_mid];
    end
    if (state_r == sndt_pkg::ST_NMS) mag_mem[ma_top] <= m_c;
  end

  always_ff @(posedge clk) begin
    if (state_r == sndt_pkg::ST_WIN) dold_r <= dir_mem[mc_r];
    if (state_r == sndt_pkg::ST_NMS) dir_mem[mc_r] <= dm_c;
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept && go) begin
      drain_r <= is_drain;
      emit_r  <= emit;
      if (is_drain) begin
        ir_r  <= drow;
        ic_r  <= COL_W'(dcol);
        pix_r <= 8'd0;
      end else begin
        ir_r  <= $signed({2'b00, in_row_n});
        ic_r  <= in_col_n;
        pix_r <= in_pixel;
      end
    end
    if (state_r == sndt_pkg::ST_READ) begin
      mr_r      <= mr_c;
      mc_r      <= mc_c;
      grad_ok_r <= (ic_r >= COL_W'(2)) && (ir_r >= RS'(2)) && (ir_r <= h_s - RS'(1));
    end
    if (state_r == sndt_pkg::ST_GRAD) begin
      gx_r <= gx_c;
      gy_r <= gy_c;
    end
    if (state_r == sndt_pkg::ST_MUL1) begin
      ax_r    <= ax_c;
      ay_r    <= ay_c;
      gxneg_r <= gxf[10];
      sq_r    <= sq_c;
    end
    if (state_r == sndt_pkg::ST_MUL2) begin
      d_r   <= d_c;
      sr_r  <= '0;
      cnt_r <= '0;
    end
    if (state_r == sndt_pkg::ST_SQRT) begin
      cnt_r <= cnt_r + 4'd1;
      if ({1'b0, sq_r} >= rb) begin
        sq_r <= sq_r - rb[20:0];
        sr_r <= (sr_r >> 1) + bitv;
      end else begin
        sr_r <= sr_r >> 1;
      end
    end
    if (state_r == sndt_pkg::ST_EVAL) begin
      res_val_r <= val;
      res_eol_r <= (WID_W'(nc) == w_eff - WID_W'(1));
      res_eof_r <= (WID_W'(nc) == w_eff - WID_W'(1)) && (nr == h_s - RS'(1));
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == sndt_pkg::ST_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == sndt_pkg::ST_OUT && out_free) begin
      out_edge_r <= res_val_r;
      out_eol_r  <= res_eol_r;
      out_eof_r  <= res_eof_r;
    end
  end

  assign in_ready         = (state_r == sndt_pkg::ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_edge_res     = out_edge_r;
  assign out_end_of_line  = out_eol_r;
  assign out_end_of_frame = out_eof_r;

endmodule
